FILE: design/bitset_membership_engine_defines.svh
// Assertion macros for the bitset membership engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BITSET_MEMBERSHIP_ENGINE_DEFINES_SVH
`define BITSET_MEMBERSHIP_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

`define BME_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bme check failed");

`define BME_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("bme check failed");

`else

`define BME_ASSERT(label, clk, rst, prop)

`define BME_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: design/bme_pkg.sv
// Types, constants and helper functions shared by the bitset membership engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bme_pkg;

   localparam int WORD_BITS    = 32;
   localparam int NUM_WORDS    = 32;
   localparam int WIDX_W       = 5;
   localparam int BIDX_W       = 5;
   localparam int ELEM_W       = 10;
   localparam int DOM_W        = 11;
   localparam int CMD_W        = 3;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WIDX_W-1:0]    widx_type;
   typedef logic [BIDX_W-1:0]    bidx_type;
   typedef logic [ELEM_W-1:0]    elem_type;
   typedef logic [DOM_W-1:0]     dom_type;
   typedef logic [CMD_W-1:0]     cmd_type;

   localparam word_type FULL_WORD   = 32'hffff_ffff;
   localparam dom_type  MAX_ELEMENTS = 11'd1024;
   localparam widx_type LAST_WORD   = 5'h1f;

   localparam cmd_type CMD_ADD    = 3'd0;
   localparam cmd_type CMD_REMOVE = 3'd1;
   localparam cmd_type CMD_TEST   = 3'd2;
   localparam cmd_type CMD_CLEAR  = 3'd3;
   localparam cmd_type CMD_FILL   = 3'd4;
   localparam cmd_type CMD_NEXT   = 3'd5;

   // control from the sequencer into the word store
   typedef struct packed {
      logic     rd_en;
      widx_type rd_addr;
      logic     wr_en;
      widx_type wr_addr;
      word_type wr_data;
      logic     clear_all;
      logic     fill_all;
   } store_ctl_type;

   // bits of word w that lie below the domain size
   function automatic word_type word_mask(input widx_type w, input dom_type dom);
      dom_type base;
      dom_type diff;
      word_type m;
      base = {1'b0, w, {BIDX_W{1'b0}}};
      diff = dom - base;
      if (dom <= base) begin
         m = '0;
      end else if (diff >= dom_type'(WORD_BITS)) begin
         m = FULL_WORD;
      end else begin
         m = ~(FULL_WORD << diff[BIDX_W-1:0]);
      end
      return m;
   endfunction

   // index of the lowest set bit; isolate it, then encode the one-hot
   function automatic bidx_type lowest_set(input word_type w);
      word_type onehot;
      bidx_type idx;
      onehot = w & (~w + word_type'(1));
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (onehot[i]) begin
            idx = idx | bidx_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: design/bme_req_if.sv
// Command channel of the bitset membership engine: valid/ready, cmd, element.
// Depends on bme_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bme_req_if;
   logic             valid;
   logic             ready;
   bme_pkg::cmd_type  cmd;
   bme_pkg::elem_type element;

   modport source (output valid, output cmd, output element, input ready);
   modport sink   (input valid, input cmd, input element, output ready);
endinterface

`default_nettype wire

FILE: design/bme_rsp_if.sv
// Result channel: valid/ready, was_member, member_count, found, next_member.
// Depends on bme_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bme_rsp_if;
   logic              valid;
   logic              ready;
   logic              was_member;
   bme_pkg::dom_type  member_count;
   logic              found;
   bme_pkg::elem_type next_member;

   modport source (output valid, output was_member, output member_count,
                   output found, output next_member, input ready);
   modport sink   (input valid, input was_member, input member_count,
                   input found, input next_member, output ready);
endinterface

`default_nettype wire

FILE: design/bitset_membership_engine.sv
// Bitset membership engine: one command at a time; add, remove, test, clear and
// fill read the word, then modify, write back and register the result.
// Next-member search walks one word per cycle until a hit or the end of the domain.
// Clear and fill act on all words at once through per-word valid bits.
// Reset (synchronous) empties the set at once, zeroes the count, domain 1024.
`timescale 1ns / 1ps
`default_nettype none
`include "bitset_membership_engine_defines.svh"

module bitset_membership_engine (
   input  wire               clock,
   input  wire               reset,
   bme_req_if.sink           req_ch,
   bme_rsp_if.source         rsp_ch,
   input  wire               csr_wr_en,
   input  bme_pkg::dom_type  csr_wr_data
);
   import bme_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic          state_ff, state_in;
   logic          first_ff, first_in;
   cmd_type       cmd_ff, cmd_in;
   elem_type      elem_ff, elem_in;
   logic          was_ff, was_in;
   widx_type      scan_w_ff, scan_w_in;
   dom_type       count_ff, count_in;
   dom_type       domain_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_was_ff, rsp_was_in;
   dom_type       rsp_count_ff, rsp_count_in;
   logic          rsp_found_ff, rsp_found_in;
   elem_type      rsp_next_ff, rsp_next_in;

   store_ctl_type ctl;
   word_type      word;
   dom_type       dom_eff;
   logic          accept;
   bidx_type      bit_sel;
   logic          in_dom;
   logic          was_now;
   word_type      hit_word;
   logic          hit;
   logic          is_search;
   dom_type       next_base;
   logic          more;
   logic          done;
   logic          stall;
   word_type      bit_mask;

   bme_word_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .dom     (dom_eff),
      .rd_word (word)
   );

   assign dom_eff      = (domain_ff > MAX_ELEMENTS) ? MAX_ELEMENTS : domain_ff;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign bit_sel   = elem_ff[BIDX_W-1:0];
   assign bit_mask  = word_type'(1) << bit_sel;
   assign in_dom    = {1'b0, elem_ff} < dom_eff;
   assign was_now   = first_ff ? (in_dom && word[bit_sel]) : was_ff;
   // first word of a search starts at the element's bit
   assign hit_word  = word & (first_ff ? (FULL_WORD << bit_sel) : FULL_WORD);
   assign hit       = |hit_word;
   assign is_search = (cmd_ff == CMD_NEXT);
   assign next_base = {1'b0, scan_w_ff, {BIDX_W{1'b0}}} + dom_type'(WORD_BITS);
   assign more      = (scan_w_ff != LAST_WORD) && (next_base < dom_eff);
   assign done      = !is_search || !in_dom || hit || !more;
   assign stall     = done && rsp_valid_ff && !rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      cmd_in       = cmd_ff;
      elem_in      = elem_ff;
      was_in       = was_ff;
      scan_w_in    = scan_w_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_was_in   = rsp_was_ff;
      rsp_count_in = rsp_count_ff;
      rsp_found_in = rsp_found_ff;
      rsp_next_in  = rsp_next_ff;
      ctl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = req_ch.element[ELEM_W-1:BIDX_W];
               scan_w_in   = req_ch.element[ELEM_W-1:BIDX_W];
               cmd_in      = req_ch.cmd;
               elem_in     = req_ch.element;
               first_in    = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stall) begin
               if (done) begin
                  unique case (cmd_ff)
                     CMD_ADD: begin
                        if (in_dom && !was_now) begin
                           ctl.wr_en   = 1'b1;
                           ctl.wr_addr = scan_w_ff;
                           ctl.wr_data = word | bit_mask;
                           count_in    = count_ff + dom_type'(1);
                        end
                     end
                     CMD_REMOVE: begin
                        if (in_dom && was_now) begin
                           ctl.wr_en   = 1'b1;
                           ctl.wr_addr = scan_w_ff;
                           ctl.wr_data = word & ~bit_mask;
                           count_in    = count_ff - dom_type'(1);
                        end
                     end
                     CMD_CLEAR: begin
                        ctl.clear_all = 1'b1;
                        count_in      = '0;
                     end
                     CMD_FILL: begin
                        ctl.fill_all = 1'b1;
                        count_in     = dom_eff;
                     end
                     default: begin
                     end
                  endcase
                  rsp_valid_in = 1'b1;
                  rsp_was_in   = was_now;
                  rsp_count_in = count_in;
                  rsp_found_in = is_search && in_dom && hit;
                  rsp_next_in  = (is_search && in_dom && hit)
                               ? {scan_w_ff, lowest_set(hit_word)} : '0;
                  state_in     = S_IDLE;
               end else begin
                  ctl.rd_en   = 1'b1;
                  ctl.rd_addr = scan_w_ff + widx_type'(1);
                  scan_w_in   = scan_w_ff + widx_type'(1);
                  was_in      = was_now;
                  first_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a domain write empties the set
      if (csr_wr_en) begin
         ctl.clear_all = 1'b1;
         count_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         domain_ff    <= MAX_ELEMENTS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            domain_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      cmd_ff       <= cmd_in;
      elem_ff      <= elem_in;
      was_ff       <= was_in;
      scan_w_ff    <= scan_w_in;
      rsp_was_ff   <= rsp_was_in;
      rsp_count_ff <= rsp_count_in;
      rsp_found_ff <= rsp_found_in;
      rsp_next_ff  <= rsp_next_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.was_member   = rsp_was_ff;
   assign rsp_ch.member_count = rsp_count_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.next_member  = rsp_next_ff;

   `BME_ASSERT(a_count_in_domain, clock, reset, count_ff <= dom_eff)
   `BME_ASSERT(a_accept_starts, clock, reset, accept |=> (state_ff == S_EXEC) && first_ff)
   `BME_ASSERT(a_write_first_only, clock, reset, ctl.wr_en |-> (state_ff == S_EXEC) && first_ff)
   `BME_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))

endmodule

`default_nettype wire

FILE: design/bme_word_store.sv
// Member word memory (32 x 32, registered read) with per-word valid bits.
// Invalid words read as empty or as the fill pattern. Depends on bme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bme_word_store (
   input  wire                   clock,
   input  wire                   reset,
   input  bme_pkg::store_ctl_type ctl,
   input  bme_pkg::dom_type       dom,
   output bme_pkg::word_type      rd_word
);
   import bme_pkg::*;

   word_type                 mem [NUM_WORDS];
   word_type                 rd_data_ff;
   widx_type                 rd_addr_ff;
   logic                     rd_valid_ff;
   logic [NUM_WORDS-1:0]     valid_ff;
   logic [NUM_WORDS-1:0]     valid_in;
   logic                     fill_ff;
   logic                     fill_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[ctl.rd_addr];
         rd_addr_ff  <= ctl.rd_addr;
         rd_valid_ff <= valid_ff[ctl.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (ctl.clear_all || ctl.fill_all) begin
         valid_in = '0;
         fill_in  = ctl.fill_all;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   // untouched words follow the last clear or fill
   assign rd_word = rd_valid_ff ? rd_data_ff
                  : (fill_ff ? word_mask(rd_addr_ff, dom) : '0);

endmodule

`default_nettype wire
